// ===== hw/rtl/ekf_landmark_update_2d_macros.svh =====
// ----------------------------------------------------------------------------
// EKF landmark update assertion macros
// Shared concurrent-assertion wrappers, clocked on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EKF_LANDMARK_UPDATE_2D_MACROS_SVH
`define EKF_LANDMARK_UPDATE_2D_MACROS_SVH

`define EKFU_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`define EKFU_IMPLIES(lbl, ante, cons, msg) \
  `EKFU_CHECK(lbl, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/ekfu_pkg.sv =====
// ----------------------------------------------------------------------------
// EKF landmark update package
// Types, constants and Q16.16 rounding/saturation helpers for the update.
// ----------------------------------------------------------------------------
package ekfu_pkg;

  localparam int QBITS    = 32;
  localparam int DIV_LAT  = QBITS + 3;
  localparam int PIPE_LAT = 12 + DIV_LAT;

  typedef logic signed [65:0] wide_t;

  localparam wide_t QMAX = 66'sd2147483647;
  localparam wide_t QMIN = -66'sd2147483648;
  localparam wide_t QONE = 66'sd65536;

  localparam logic signed [17:0] ROT_ONE     = 18'sd65536;
  localparam logic        [30:0] NOISE_RESET = 31'd39322;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_POSE_X = 3'd0;
  localparam cfg_idx_t CFG_POSE_Y = 3'd1;
  localparam cfg_idx_t CFG_ROT_00 = 3'd2;
  localparam cfg_idx_t CFG_ROT_01 = 3'd3;
  localparam cfg_idx_t CFG_ROT_10 = 3'd4;
  localparam cfg_idx_t CFG_ROT_11 = 3'd5;
  localparam cfg_idx_t CFG_NOISE  = 3'd6;

  typedef struct packed {
    logic signed [31:0] v;
    logic               f;
  } satv_t;

  // z0/z1 hold the measurement up to the innovation stage, the innovation after
  typedef struct packed {
    logic signed [31:0] m0, m1;
    logic signed [31:0] z0, z1;
    logic signed [31:0] p00, p01, p11;
    logic               sat;
  } carry_t;

  function automatic wide_t rnd16(input wide_t x);
    wide_t t;
    t = x + 66'sd32768;
    return t >>> 16;
  endfunction

  function automatic satv_t sat_mid(input wide_t x);
    satv_t r;
    if (x > QMAX) begin
      r.v = 32'sh7FFFFFFF;
      r.f = 1'b1;
    end else if (x < -QMAX) begin
      r.v = 32'sh80000001;
      r.f = 1'b1;
    end else begin
      r.v = x[31:0];
      r.f = 1'b0;
    end
    return r;
  endfunction

  function automatic satv_t sat_out(input wide_t x);
    satv_t r;
    if (x > QMAX) begin
      r.v = 32'sh7FFFFFFF;
      r.f = 1'b1;
    end else if (x < QMIN) begin
      r.v = 32'sh80000000;
      r.f = 1'b1;
    end else begin
      r.v = x[31:0];
      r.f = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/ekfu_gain_div.sv =====
// ----------------------------------------------------------------------------
// EKF gain divider
// Pipelined restoring divider: round(num * 2^16 / den), one quotient bit per
// stage, saturating to +-(2^31 - 1); zero divisor gives zero and a flag.
// ----------------------------------------------------------------------------
module ekfu_gain_div (
  input  logic               clk,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic signed [31:0] gain,
  output logic               gain_sat
);

  localparam int NS = ekfu_pkg::QBITS;

  logic              neg_a_r, zero_a_r;
  logic [63:0]       un_a_r, ud_a_r;

  logic [64:0]       rem_r  [0:NS];
  logic [NS-1:0]     quo_r  [0:NS];
  logic [NS-1:0]     low_r  [0:NS];
  logic [63:0]       ud_r   [0:NS];
  logic              neg_r  [0:NS];
  logic              zero_r [0:NS];
  logic              over_r [0:NS];

  logic [64:0]       trial  [0:NS-1];
  logic              ge     [0:NS-1];
  logic              half;
  logic [NS:0]       qrnd;
  logic              big;
  logic [NS-1:0]     mag;

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      trial[s] = {rem_r[s][63:0], low_r[s][NS-1]};
      ge[s]    = trial[s] >= {1'b0, ud_r[s]};
    end
    half = {rem_r[NS][63:0], 1'b0} >= {1'b0, ud_r[NS]};
    qrnd = {1'b0, quo_r[NS]} + {{NS{1'b0}}, half};
    big  = over_r[NS] | (qrnd > {2'b00, {(NS-1){1'b1}}});
    mag  = big ? {1'b0, {(NS-1){1'b1}}} : qrnd[NS-1:0];
  end

  always_ff @(posedge clk) begin
    neg_a_r  <= num[63] ^ den[63];
    un_a_r   <= num[63] ? 64'(-num) : 64'(num);
    ud_a_r   <= den[63] ? 64'(-den) : 64'(den);
    zero_a_r <= den == '0;

    rem_r[0]  <= 65'(un_a_r[63:16]);
    over_r[0] <= {16'h0, un_a_r[63:16]} >= ud_a_r;
    low_r[0]  <= {un_a_r[15:0], 16'h0};
    quo_r[0]  <= '0;
    ud_r[0]   <= ud_a_r;
    neg_r[0]  <= neg_a_r;
    zero_r[0] <= zero_a_r;

    for (int s = 0; s < NS; s++) begin
      rem_r[s+1]  <= ge[s] ? trial[s] - {1'b0, ud_r[s]} : trial[s];
      quo_r[s+1]  <= {quo_r[s][NS-2:0], ge[s]};
      low_r[s+1]  <= low_r[s] << 1;
      ud_r[s+1]   <= ud_r[s];
      neg_r[s+1]  <= neg_r[s];
      zero_r[s+1] <= zero_r[s];
      over_r[s+1] <= over_r[s];
    end

    gain     <= zero_r[NS] ? '0 : (neg_r[NS] ? -mag : mag);
    gain_sat <= zero_r[NS] | big;
  end

endmodule

// ===== hw/rtl/ekf_landmark_update_2d.sv =====
// ----------------------------------------------------------------------------
// EKF landmark update, 2-D
// Kalman correction of one landmark mean and covariance in Q16.16.
// ----------------------------------------------------------------------------
// Takes one item per clock and returns its result on a one-cycle out_valid
// strobe; the receiver cannot stall, and items never wait on each other. The
// pipeline is twelve arithmetic stages plus the 35-stage gain divider, whose
// core gives one quotient bit per stage. busy is high only while rst_n is
// low. Configuration writes are taken every cycle (cfg_ready is high) and
// must only be issued while no item is in flight.
module ekf_landmark_update_2d (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_mean_x,
  input  logic signed [31:0] in_mean_y,
  input  logic        [30:0] in_cov_xx,
  input  logic signed [31:0] in_cov_xy,
  input  logic        [30:0] in_cov_yy,
  input  logic signed [31:0] in_meas_x,
  input  logic signed [31:0] in_meas_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data,
  output logic               out_valid,
  output logic signed [31:0] out_new_mean_x,
  output logic signed [31:0] out_new_mean_y,
  output logic signed [31:0] out_new_cov_xx,
  output logic signed [31:0] out_new_cov_xy,
  output logic signed [31:0] out_new_cov_yy,
  output logic               out_saturated
);

`include "ekf_landmark_update_2d_macros.svh"

  localparam int DL = ekfu_pkg::DIV_LAT;

  // configuration
  logic signed [31:0] pose_x_r, pose_y_r;
  logic signed [17:0] rot_r [2][2];
  logic        [30:0] noise_r;

  logic accept;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      rot_r[0][0] <= ekfu_pkg::ROT_ONE;
      rot_r[0][1] <= '0;
      rot_r[1][0] <= '0;
      rot_r[1][1] <= ekfu_pkg::ROT_ONE;
      noise_r     <= ekfu_pkg::NOISE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ekfu_pkg::CFG_POSE_X: pose_x_r    <= cfg_data;
        ekfu_pkg::CFG_POSE_Y: pose_y_r    <= cfg_data;
        ekfu_pkg::CFG_ROT_00: rot_r[0][0] <= cfg_data[17:0];
        ekfu_pkg::CFG_ROT_01: rot_r[0][1] <= cfg_data[17:0];
        ekfu_pkg::CFG_ROT_10: rot_r[1][0] <= cfg_data[17:0];
        ekfu_pkg::CFG_ROT_11: rot_r[1][1] <= cfg_data[17:0];
        ekfu_pkg::CFG_NOISE:  noise_r     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // valid chain
  logic vld_r [1:12];
  logic dvld_r [0:DL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 1; n <= 12; n++) vld_r[n] <= 1'b0;
      for (int n = 0; n < DL; n++) dvld_r[n] <= 1'b0;
    end else begin
      vld_r[1] <= accept;
      for (int n = 2; n <= 7; n++) vld_r[n] <= vld_r[n-1];
      dvld_r[0] <= vld_r[7];
      for (int n = 1; n < DL; n++) dvld_r[n] <= dvld_r[n-1];
      vld_r[8] <= dvld_r[DL-1];
      for (int n = 9; n <= 12; n++) vld_r[n] <= vld_r[n-1];
    end
  end

  // stage 1: relative position
  ekfu_pkg::carry_t   c1_r;
  logic signed [31:0] rel_r [2];
  ekfu_pkg::satv_t    rel0, rel1;

  always_comb begin
    rel0 = ekfu_pkg::sat_mid(ekfu_pkg::wide_t'(in_mean_x) - ekfu_pkg::wide_t'(pose_x_r));
    rel1 = ekfu_pkg::sat_mid(ekfu_pkg::wide_t'(in_mean_y) - ekfu_pkg::wide_t'(pose_y_r));
  end

  always_ff @(posedge clk) begin
    c1_r.m0  <= in_mean_x;
    c1_r.m1  <= in_mean_y;
    c1_r.z0  <= in_meas_x;
    c1_r.z1  <= in_meas_y;
    c1_r.p00 <= {1'b0, in_cov_xx};
    c1_r.p01 <= in_cov_xy;
    c1_r.p11 <= {1'b0, in_cov_yy};
    c1_r.sat <= rel0.f | rel1.f;
    rel_r[0] <= rel0.v;
    rel_r[1] <= rel1.v;
  end

  // stage 2: products for h and A = R P (B = P R^T = A^T)
  ekfu_pkg::carry_t   c2_r;
  logic signed [31:0] p1 [2][2];
  logic signed [49:0] ph_r [2][2];
  logic signed [49:0] pa_r [2][2][2];

  always_comb begin
    p1[0][0] = c1_r.p00;
    p1[0][1] = c1_r.p01;
    p1[1][0] = c1_r.p01;
    p1[1][1] = c1_r.p11;
  end

  always_ff @(posedge clk) begin
    c2_r <= c1_r;
    for (int i = 0; i < 2; i++) begin
      for (int k = 0; k < 2; k++) begin
        ph_r[i][k] <= rot_r[i][k] * rel_r[k];
        for (int j = 0; j < 2; j++) pa_r[i][j][k] <= rot_r[i][k] * p1[k][j];
      end
    end
  end

  // stage 3: h and A
  ekfu_pkg::carry_t   c3_r;
  logic signed [31:0] h_r [2];
  logic signed [31:0] a_r [2][2];
  ekfu_pkg::satv_t    h3 [2];
  ekfu_pkg::satv_t    a3 [2][2];
  logic               f3;

  always_comb begin
    f3 = 1'b0;
    for (int i = 0; i < 2; i++) begin
      h3[i] = ekfu_pkg::sat_mid(ekfu_pkg::rnd16(ekfu_pkg::wide_t'(ph_r[i][0])
                                                + ekfu_pkg::wide_t'(ph_r[i][1])));
      f3 = f3 | h3[i].f;
      for (int j = 0; j < 2; j++) begin
        a3[i][j] = ekfu_pkg::sat_mid(ekfu_pkg::rnd16(ekfu_pkg::wide_t'(pa_r[i][j][0])
                                                     + ekfu_pkg::wide_t'(pa_r[i][j][1])));
        f3 = f3 | a3[i][j].f;
      end
    end
  end

  always_ff @(posedge clk) begin
    c3_r     <= c2_r;
    c3_r.sat <= c2_r.sat | f3;
    for (int i = 0; i < 2; i++) begin
      h_r[i] <= h3[i].v;
      for (int j = 0; j < 2; j++) a_r[i][j] <= a3[i][j].v;
    end
  end

  // stage 4: products for S, innovation
  ekfu_pkg::carry_t   c4_r;
  logic signed [31:0] a4_r [2][2];
  logic signed [49:0] ps_r [2][2][2];
  ekfu_pkg::satv_t    e0, e1;

  always_comb begin
    e0 = ekfu_pkg::sat_mid(ekfu_pkg::wide_t'(c3_r.z0) - ekfu_pkg::wide_t'(h_r[0]));
    e1 = ekfu_pkg::sat_mid(ekfu_pkg::wide_t'(c3_r.z1) - ekfu_pkg::wide_t'(h_r[1]));
  end

  always_ff @(posedge clk) begin
    c4_r     <= c3_r;
    c4_r.z0  <= e0.v;
    c4_r.z1  <= e1.v;
    c4_r.sat <= c3_r.sat | e0.f | e1.f;
    a4_r     <= a_r;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        for (int k = 0; k < 2; k++) ps_r[i][j][k] <= a_r[i][k] * rot_r[j][k];
  end

  // stage 5: S = R P R^T + q I
  ekfu_pkg::carry_t   c5_r;
  logic signed [31:0] a5_r [2][2];
  logic signed [31:0] s_r [2][2];
  ekfu_pkg::satv_t    s5 [2][2];
  logic               f5;

  always_comb begin
    f5 = 1'b0;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        s5[i][j] = ekfu_pkg::sat_mid(
            ekfu_pkg::rnd16(ekfu_pkg::wide_t'(ps_r[i][j][0]) + ekfu_pkg::wide_t'(ps_r[i][j][1]))
            + ((i == j) ? ekfu_pkg::wide_t'({1'b0, noise_r}) : ekfu_pkg::wide_t'(0)));
        f5 = f5 | s5[i][j].f;
      end
    end
  end

  always_ff @(posedge clk) begin
    c5_r     <= c4_r;
    c5_r.sat <= c4_r.sat | f5;
    a5_r     <= a4_r;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) s_r[i][j] <= s5[i][j].v;
  end

  // stage 6: determinant and B adj(S) products, B[i][k] = A[k][i]
  ekfu_pkg::carry_t   c6_r;
  logic signed [63:0] pd_r [2];
  logic signed [63:0] pn_r [2][2][2];

  always_ff @(posedge clk) begin
    c6_r     <= c5_r;
    pd_r[0]  <= s_r[0][0] * s_r[1][1];
    pd_r[1]  <= s_r[0][1] * s_r[1][0];
    for (int i = 0; i < 2; i++) begin
      pn_r[i][0][0] <= a5_r[0][i] * s_r[1][1];
      pn_r[i][0][1] <= a5_r[1][i] * s_r[1][0];
      pn_r[i][1][0] <= a5_r[1][i] * s_r[0][0];
      pn_r[i][1][1] <= a5_r[0][i] * s_r[0][1];
    end
  end

  // stage 7: determinant and gain numerators
  ekfu_pkg::carry_t   c7_r;
  logic signed [63:0] det_r;
  logic signed [63:0] num_r [2][2];
  ekfu_pkg::wide_t    det7;
  ekfu_pkg::wide_t    num7 [2][2];

  always_comb begin
    det7 = ekfu_pkg::wide_t'(pd_r[0]) - ekfu_pkg::wide_t'(pd_r[1]);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        num7[i][j] = ekfu_pkg::wide_t'(pn_r[i][j][0]) - ekfu_pkg::wide_t'(pn_r[i][j][1]);
  end

  always_ff @(posedge clk) begin
    c7_r  <= c6_r;
    det_r <= det7[63:0];
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) num_r[i][j] <= num7[i][j][63:0];
  end

  // gain dividers, payload delayed alongside
  logic signed [31:0] k_w   [2][2];
  logic               ksat_w [2][2];
  ekfu_pkg::carry_t   dly_r [0:DL-1];

  for (genvar gi = 0; gi < 2; gi++) begin : g_row
    for (genvar gj = 0; gj < 2; gj++) begin : g_col
      ekfu_gain_div u_div (
        .clk      (clk),
        .num      (num_r[gi][gj]),
        .den      (det_r),
        .gain     (k_w[gi][gj]),
        .gain_sat (ksat_w[gi][gj])
      );
    end
  end

  always_ff @(posedge clk) begin
    dly_r[0] <= c7_r;
    for (int n = 1; n < DL; n++) dly_r[n] <= dly_r[n-1];
  end

  // stage 8: K e and K R products
  ekfu_pkg::carry_t   c8_r;
  logic signed [63:0] pk_r [2][2];
  logic signed [49:0] pc_r [2][2][2];
  logic signed [31:0] ev [2];

  always_comb begin
    ev[0] = dly_r[DL-1].z0;
    ev[1] = dly_r[DL-1].z1;
  end

  always_ff @(posedge clk) begin
    c8_r     <= dly_r[DL-1];
    c8_r.sat <= dly_r[DL-1].sat | ksat_w[0][0] | ksat_w[0][1]
                | ksat_w[1][0] | ksat_w[1][1];
    for (int i = 0; i < 2; i++)
      for (int k = 0; k < 2; k++) begin
        pk_r[i][k] <= k_w[i][k] * ev[k];
        for (int j = 0; j < 2; j++) pc_r[i][j][k] <= k_w[i][k] * rot_r[k][j];
      end
  end

  // stage 9: rounded sums
  ekfu_pkg::carry_t   c9_r;
  logic signed [49:0] t_r [2];
  logic signed [49:0] cr_r [2][2];
  ekfu_pkg::wide_t    t9 [2];
  ekfu_pkg::wide_t    cr9 [2][2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      t9[i] = ekfu_pkg::rnd16(ekfu_pkg::wide_t'(pk_r[i][0]) + ekfu_pkg::wide_t'(pk_r[i][1]));
      for (int j = 0; j < 2; j++)
        cr9[i][j] = ekfu_pkg::rnd16(ekfu_pkg::wide_t'(pc_r[i][j][0])
                                    + ekfu_pkg::wide_t'(pc_r[i][j][1]));
    end
  end

  always_ff @(posedge clk) begin
    c9_r <= c8_r;
    for (int i = 0; i < 2; i++) begin
      t_r[i] <= t9[i][49:0];
      for (int j = 0; j < 2; j++) cr_r[i][j] <= cr9[i][j][49:0];
    end
  end

  // stage 10: new mean, C = I - K R
  ekfu_pkg::carry_t   c10_r;
  logic signed [31:0] nm_r [2];
  logic signed [31:0] cm_r [2][2];
  ekfu_pkg::satv_t    nm10 [2];
  ekfu_pkg::satv_t    cm10 [2][2];
  logic               f10;

  always_comb begin
    f10 = 1'b0;
    nm10[0] = ekfu_pkg::sat_out(ekfu_pkg::wide_t'(c9_r.m0) + ekfu_pkg::wide_t'(t_r[0]));
    nm10[1] = ekfu_pkg::sat_out(ekfu_pkg::wide_t'(c9_r.m1) + ekfu_pkg::wide_t'(t_r[1]));
    f10 = nm10[0].f | nm10[1].f;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) begin
        cm10[i][j] = ekfu_pkg::sat_mid(((i == j) ? ekfu_pkg::QONE : ekfu_pkg::wide_t'(0))
                                       - ekfu_pkg::wide_t'(cr_r[i][j]));
        f10 = f10 | cm10[i][j].f;
      end
  end

  always_ff @(posedge clk) begin
    c10_r     <= c9_r;
    c10_r.sat <= c9_r.sat | f10;
    for (int i = 0; i < 2; i++) begin
      nm_r[i] <= nm10[i].v;
      for (int j = 0; j < 2; j++) cm_r[i][j] <= cm10[i][j].v;
    end
  end

  // stage 11: C P products for entries (0,0), (0,1), (1,1)
  ekfu_pkg::carry_t   c11_r;
  logic signed [31:0] nm11_r [2];
  logic signed [63:0] q_r [6];

  always_ff @(posedge clk) begin
    c11_r  <= c10_r;
    nm11_r <= nm_r;
    q_r[0] <= cm_r[0][0] * c10_r.p00;
    q_r[1] <= cm_r[0][1] * c10_r.p01;
    q_r[2] <= cm_r[0][0] * c10_r.p01;
    q_r[3] <= cm_r[0][1] * c10_r.p11;
    q_r[4] <= cm_r[1][0] * c10_r.p01;
    q_r[5] <= cm_r[1][1] * c10_r.p11;
  end

  // stage 12: new covariance, output register
  ekfu_pkg::satv_t np [3];

  always_comb begin
    for (int n = 0; n < 3; n++)
      np[n] = ekfu_pkg::sat_out(ekfu_pkg::rnd16(ekfu_pkg::wide_t'(q_r[2*n])
                                                + ekfu_pkg::wide_t'(q_r[2*n+1])));
  end

  always_ff @(posedge clk) begin
    out_new_mean_x <= nm11_r[0];
    out_new_mean_y <= nm11_r[1];
    out_new_cov_xx <= np[0].v;
    out_new_cov_xy <= np[1].v;
    out_new_cov_yy <= np[2].v;
    out_saturated  <= c11_r.sat | np[0].f | np[1].f | np[2].f;
  end

  assign out_valid = vld_r[12];

  `EKFU_IMPLIES(a_latency, out_valid, $past(start && !busy, ekfu_pkg::PIPE_LAT), "result without matching item")
  `EKFU_IMPLIES(a_singular, $past(vld_r[7] && det_r == '0, DL), (k_w[0][0] == '0 && k_w[0][1] == '0 && k_w[1][0] == '0 && k_w[1][1] == '0 && ksat_w[0][0] && ksat_w[1][1]), "singular S gave nonzero gain")
  `EKFU_IMPLIES(a_sat_carry, vld_r[8] && $past(ksat_w[0][0] || ksat_w[0][1] || ksat_w[1][0] || ksat_w[1][1]), c8_r.sat, "gain saturation lost")

endmodule

// ===== test/tb_ekf_landmark_update_2d.sv =====
// ----------------------------------------------------------------------------
// EKF landmark update testbench
// Drives landmark items through the 2-D Kalman correction under several
// register settings, predicts each result in Q16.16 and checks every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ekf_landmark_update_2d;

  localparam int LATENCY   = ekfu_pkg::PIPE_LAT + 8;
  localparam int CYCLE_MAX = 200000;
  localparam ekfu_pkg::cfg_idx_t CFG_UNUSED = 3'd7;

  typedef logic signed [127:0] big_t;

  typedef struct packed {
    logic signed [31:0] mx, my;
    logic        [30:0] pxx;
    logic signed [31:0] pxy;
    logic        [30:0] pyy;
    logic signed [31:0] zx, zy;
  } landmark_t;

  typedef struct packed {
    logic signed [31:0] mx, my, pxx, pxy, pyy;
    logic               sat;
  } update_t;

  logic clk, rst_n, start, busy, cfg_valid, cfg_ready, out_valid;
  logic signed [31:0] in_mean_x, in_mean_y, in_cov_xy, in_meas_x, in_meas_y;
  logic        [30:0] in_cov_xx, in_cov_yy;
  logic        [2:0]  cfg_index;
  logic        [31:0] cfg_data;
  logic signed [31:0] out_new_mean_x, out_new_mean_y, out_new_cov_xx;
  logic signed [31:0] out_new_cov_xy, out_new_cov_yy;
  logic               out_saturated;

  ekf_landmark_update_2d i_dut (.*);

  // predictor copy of registers
  big_t pose[2];
  big_t rot[2][2];
  big_t noise;

  update_t pending_updates[$];
  int  errors;
  int  cycles;
  bit  idle_on;
  bit  flag;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic big_t clip_mid(big_t x);
    if (x > 128'sd2147483647) begin flag = 1; return 128'sd2147483647; end
    if (x < -128'sd2147483647) begin flag = 1; return -128'sd2147483647; end
    return x;
  endfunction

  function automatic big_t clip_out(big_t x);
    if (x > 128'sd2147483647) begin flag = 1; return 128'sd2147483647; end
    if (x < -128'sd2147483648) begin flag = 1; return -128'sd2147483648; end
    return x;
  endfunction

  function automatic big_t q16(big_t x);
    return (x + 128'sd32768) >>> 16;
  endfunction

  function automatic big_t gain_quot(big_t num, big_t den);
    big_t un, ud, q, r;
    bit neg;
    neg = (num < 0) != (den < 0);
    un  = (num < 0) ? -num : num;
    ud  = (den < 0) ? -den : den;
    un  = un <<< 16;
    q   = un / ud;
    r   = un % ud;
    if (q >= (128'sd1 <<< 32)) begin
      flag = 1;
      return neg ? -128'sd2147483647 : 128'sd2147483647;
    end
    if (r * 2 >= ud) q = q + 1;
    return clip_mid(neg ? -q : q);
  endfunction

  function automatic update_t kalman_correct(landmark_t it);
    big_t m[2], z[2], p[2][2], rel[2], h[2], e[2], a[2][2], b[2][2];
    big_t s[2][2], adj[2][2], k[2][2], c[2][2], np[2][2], nm[2], det;
    update_t r;
    flag = 0;
    m[0] = it.mx; m[1] = it.my; z[0] = it.zx; z[1] = it.zy;
    p[0][0] = {1'b0, it.pxx}; p[0][1] = it.pxy; p[1][0] = it.pxy;
    p[1][1] = {1'b0, it.pyy};
    for (int i = 0; i < 2; i++) rel[i] = clip_mid(m[i] - pose[i]);
    for (int i = 0; i < 2; i++)
      h[i] = clip_mid(q16(rot[i][0] * rel[0] + rot[i][1] * rel[1]));
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) begin
        a[i][j] = clip_mid(q16(rot[i][0] * p[0][j] + rot[i][1] * p[1][j]));
        b[i][j] = clip_mid(q16(p[i][0] * rot[j][0] + p[i][1] * rot[j][1]));
      end
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        s[i][j] = clip_mid(q16(a[i][0] * rot[j][0] + a[i][1] * rot[j][1])
                           + (i == j ? noise : 0));
    det = s[0][0] * s[1][1] - s[0][1] * s[1][0];
    adj[0][0] = s[1][1]; adj[0][1] = -s[0][1];
    adj[1][0] = -s[1][0]; adj[1][1] = s[0][0];
    if (det == 0) flag = 1;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        k[i][j] = (det == 0) ? 0 :
          gain_quot(b[i][0] * adj[0][j] + b[i][1] * adj[1][j], det);
    for (int i = 0; i < 2; i++) e[i] = clip_mid(z[i] - h[i]);
    for (int i = 0; i < 2; i++)
      nm[i] = clip_out(m[i] + q16(k[i][0] * e[0] + k[i][1] * e[1]));
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        c[i][j] = clip_mid((i == j ? 128'sd65536 : 0)
                           - q16(k[i][0] * rot[0][j] + k[i][1] * rot[1][j]));
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        np[i][j] = clip_out(q16(c[i][0] * p[0][j] + c[i][1] * p[1][j]));
    r.mx = nm[0][31:0]; r.my = nm[1][31:0];
    r.pxx = np[0][0][31:0]; r.pxy = np[0][1][31:0]; r.pyy = np[1][1][31:0];
    r.sat = flag;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    update_t w;
    if (rst_n && out_valid) begin
      if (pending_updates.size() == 0) begin
        $display("unexpected result at cycle %0d", cycles);
        errors++;
      end else begin
        w = pending_updates.pop_front();
        if (out_new_mean_x !== w.mx) report_mismatch("mean_x", out_new_mean_x, w.mx);
        if (out_new_mean_y !== w.my) report_mismatch("mean_y", out_new_mean_y, w.my);
        if (out_new_cov_xx !== w.pxx) report_mismatch("cov_xx", out_new_cov_xx, w.pxx);
        if (out_new_cov_xy !== w.pxy) report_mismatch("cov_xy", out_new_cov_xy, w.pxy);
        if (out_new_cov_yy !== w.pyy) report_mismatch("cov_yy", out_new_cov_yy, w.pyy);
        if (out_saturated !== w.sat)
          report_mismatch("saturated", {31'b0, out_saturated}, {31'b0, w.sat});
      end
    end
  end

  task automatic send_landmark(landmark_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    start     <= 1'b1;
    in_mean_x <= it.mx;  in_mean_y <= it.my;
    in_cov_xx <= it.pxx; in_cov_xy <= it.pxy; in_cov_yy <= it.pyy;
    in_meas_x <= it.zx;  in_meas_y <= it.zy;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_updates.push_back(kalman_correct(it));
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(negedge clk);
    while (pending_updates.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(ekfu_pkg::cfg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ekfu_pkg::CFG_POSE_X: pose[0] = $signed(val);
      ekfu_pkg::CFG_POSE_Y: pose[1] = $signed(val);
      ekfu_pkg::CFG_ROT_00: rot[0][0] = $signed(val[17:0]);
      ekfu_pkg::CFG_ROT_01: rot[0][1] = $signed(val[17:0]);
      ekfu_pkg::CFG_ROT_10: rot[1][0] = $signed(val[17:0]);
      ekfu_pkg::CFG_ROT_11: rot[1][1] = $signed(val[17:0]);
      ekfu_pkg::CFG_NOISE:  noise = {1'b0, val[30:0]};
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_q(int span);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  function automatic landmark_t rand_landmark();
    landmark_t it;
    it.mx = rand_q(2000000); it.my = rand_q(2000000);
    it.zx = rand_q(2000000); it.zy = rand_q(2000000);
    it.pxx = 31'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 400000));
    it.pyy = 31'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 400000));
    it.pxy = $urandom_range(0, 7) == 0 ? $urandom
             : $signed($urandom_range(0, 200000)) - 100000;
    return it;
  endfunction

  function automatic logic [31:0] rand_rot();
    case ($urandom_range(0, 4))
      0: return 32'h10000;
      1: return 32'h30000;
      2: return 32'h0;
      default: return $signed($urandom_range(0, 131072)) - 65536;
    endcase
  endfunction

  task automatic test_extremes;
    landmark_t it;
    it = '0;
    send_landmark(it);
    it = '{32'sh7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF, 32'sh7FFFFFFF,
           31'h7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF};
    send_landmark(it);
    it = '{32'sh80000000, 32'sh7FFFFFFF, 31'h0, 32'sh80000000,
           31'h0, 32'sh7FFFFFFF, 32'sh80000000};
    send_landmark(it);
    it = '{32'sh00010000, 32'shFFFF0000, 31'h10000, 32'sh8000,
           31'h20000, 32'sh00020000, 32'sh0};
    send_landmark(it);
    it = '{32'sh55555555, 32'shAAAAAAAA, 31'h2AAAAAAA, 32'sh55555555,
           31'h55555555, 32'shAAAAAAAA, 32'sh55555555};
    send_landmark(it);
    for (int i = 0; i < 8; i++) send_landmark(rand_landmark());
    drain();
  endtask

  // zero noise and zero covariance make S singular
  task automatic test_singular;
    landmark_t it;
    write_reg(ekfu_pkg::CFG_NOISE, 32'h0);
    it = '0;
    it.mx = 32'sh30000; it.zx = 32'sh10000;
    send_landmark(it);
    it.pxx = 31'h10000;
    send_landmark(it);
    drain();
    // rank-deficient R
    write_reg(ekfu_pkg::CFG_ROT_10, 32'h10000);
    write_reg(ekfu_pkg::CFG_ROT_11, 32'h0);
    it.pyy = 31'h20000;
    send_landmark(it);
    drain();
    // indefinite S through an indefinite covariance P
    write_reg(ekfu_pkg::CFG_NOISE, 32'h100);
    write_reg(ekfu_pkg::CFG_ROT_11, 32'h30000);
    write_reg(ekfu_pkg::CFG_ROT_01, 32'h10000);
    it.pxy = 32'sh30000;
    send_landmark(it);
    drain();
  endtask

  task automatic test_random_phase(int count);
    write_reg(ekfu_pkg::CFG_POSE_X, rand_q(2000000));
    write_reg(ekfu_pkg::CFG_POSE_Y, rand_q(2000000));
    write_reg(ekfu_pkg::CFG_ROT_00, rand_rot());
    write_reg(ekfu_pkg::CFG_ROT_01, rand_rot());
    write_reg(ekfu_pkg::CFG_ROT_10, rand_rot());
    write_reg(ekfu_pkg::CFG_ROT_11, rand_rot());
    case ($urandom_range(0, 3))
      0: write_reg(ekfu_pkg::CFG_NOISE, 32'h7FFFFFFF);
      1: write_reg(ekfu_pkg::CFG_NOISE, 32'h0);
      default: write_reg(ekfu_pkg::CFG_NOISE, $urandom_range(1, 400000));
    endcase
    if ($urandom_range(0, 1)) write_reg(CFG_UNUSED, $urandom);
    for (int i = 0; i < count; i++) send_landmark(rand_landmark());
    drain();
  endtask

  initial begin
    errors = 0; cycles = 0; idle_on = 1;
    rst_n = 1'b0; start = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_mean_x = '0; in_mean_y = '0; in_cov_xx = '0; in_cov_xy = '0;
    in_cov_yy = '0; in_meas_x = '0; in_meas_y = '0;
    pose[0] = 0; pose[1] = 0; noise = 39322;
    rot[0][0] = 65536; rot[0][1] = 0; rot[1][0] = 0; rot[1][1] = 65536;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_singular();
    write_reg(ekfu_pkg::CFG_POSE_X, 32'h80000000);
    write_reg(ekfu_pkg::CFG_POSE_Y, 32'h7FFFFFFF);
    write_reg(ekfu_pkg::CFG_ROT_00, 32'h30000);
    write_reg(ekfu_pkg::CFG_ROT_01, 32'h10000);
    write_reg(ekfu_pkg::CFG_ROT_10, 32'h30000);
    write_reg(ekfu_pkg::CFG_ROT_11, 32'h10000);
    for (int i = 0; i < 6; i++) send_landmark(rand_landmark());
    drain();
    for (int ph = 0; ph < 6; ph++) test_random_phase(50);
    idle_on = 0;
    test_random_phase(80);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ekfu_pkg.sv
hw/rtl/ekfu_gain_div.sv
hw/rtl/ekf_landmark_update_2d.sv
test/tb_ekf_landmark_update_2d.sv
